/* rtl/core/pscl_pkg.sv */
package pscl_pkg;

   typedef enum logic [1:0] {
      OP_ACCEPT = 2'd0,
      OP_CLOSE  = 2'd1,
      OP_SWEEP  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_LIMIT      = 2'd1,
      ST_TABLE_FULL = 2'd2,
      ST_QUEUE_FULL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_LIMIT  = 2'd0,
      CSR_WINDOW = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_WAIT,
      S_UPDATE,
      S_Q_READ,
      S_Q_WAIT,
      S_Q_CHECK,
      S_DONE
   } state_type;

   localparam logic [15:0] PRIO_THRESHOLD = 16'd8;
   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
   localparam logic [8:0]  TALLY_MAX      = 9'h1FF;

   // request from sequencer to table search unit
   typedef struct packed {
      logic        start;
      logic [63:0] key;
   } search_req_type;

   typedef struct packed {
      logic done;
      logic found;
      logic free_found;
   } search_rsp_type;

endpackage

/* rtl/core/per_source_connection_limiter.sv */
// channel   ports                                        direction
// request   start req_opcode req_prefix req_event_time       in; busy out
// response  rsp_valid rsp_accepted rsp_priority_res rsp_status rsp_expired_count  out
// config    csr_write csr_index csr_data                 in
//
// accept: one table scan, then update and result
// close: queued in the close fifo, or a table scan that releases the entry when the close fifo is full
// sweep: per expired close a fifo read plus a table scan, then the result
// reset clears the valid bits at once; no clearing pass
// the result strobe lasts one cycle and cannot be held off
module per_source_connection_limiter #(
   parameter int TABLE_DEPTH = 64,
   parameter int QUEUE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [63:0] req_prefix,
   input  logic [31:0] req_event_time,
   output logic        rsp_valid,
   output logic        rsp_accepted,
   output logic signed [16:0] rsp_priority_res,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_expired_count,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import pscl_pkg::*;

   localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   state_type     state_ff, state_in;
   logic [15:0]   limit_ff;
   logic [31:0]   window_ff;
   opcode_type    op_ff, op_in;
   logic [63:0]   key_ff, key_in;
   logic [31:0]   tick_ff, tick_in;
   logic [QW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [8:0]    tally_ff, tally_in;
   logic          release_ff, release_in;
   logic          acc_ff, acc_in;
   logic [16:0]   prio_ff, prio_in;
   status_type    status_ff, status_in;
   logic          valid_ff, valid_in;

   search_req_type sreq;
   search_rsp_type srsp;
   logic [TW-1:0]  hit_index, free_index, wr_index;
   logic [15:0]    hit_count, wr_count, new_count;
   logic           wr_en, wr_valid, push;
   logic [63:0]    q_prefix;
   logic [31:0]    q_time;

   pscl_table #(.TABLE_DEPTH(TABLE_DEPTH), .TW(TW)) u_table (
      .clock, .reset, .search_req(sreq), .search_rsp(srsp),
      .hit_index, .free_index, .hit_count,
      .wr_en, .wr_index, .wr_valid, .wr_prefix(key_ff), .wr_count
   );

   pscl_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .QW(QW)) u_queue (
      .clock, .push, .push_addr(tail_ff), .push_prefix(key_ff),
      .push_time(tick_ff), .rd_addr(head_ff),
      .rd_prefix(q_prefix), .rd_time(q_time)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
         window_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LIMIT:  limit_ff <= csr_data[15:0];
            CSR_WINDOW: window_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      key_in = key_ff;
      tick_in = tick_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      tally_in = tally_ff;
      release_in = release_ff;
      acc_in = acc_ff;
      prio_in = prio_ff;
      status_in = status_ff;
      valid_in = 1'b0;
      sreq.start = 1'b0;
      sreq.key = key_ff;
      wr_en = 1'b0;
      wr_valid = 1'b1;
      wr_index = hit_index;
      wr_count = 16'd1;
      push = 1'b0;
      new_count = (hit_count < COUNT_MAX) ? hit_count + 16'd1 : hit_count;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = opcode_type'(req_opcode);
               key_in = req_prefix;
               tick_in = req_event_time;
               tally_in = '0;
               acc_in = 1'b0;
               prio_in = '0;
               status_in = ST_OK;
               release_in = 1'b0;
               case (opcode_type'(req_opcode))
                  OP_ACCEPT: state_in = S_SCAN;
                  OP_CLOSE: begin
                     if (fill_ff < FW'(QUEUE_DEPTH)) begin
                        state_in = S_DONE;
                        push = 1'b0;
                     end else begin
                        release_in = 1'b1;
                        status_in = ST_QUEUE_FULL;
                        state_in = S_SCAN;
                     end
                  end
                  OP_SWEEP: state_in = S_Q_READ;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            sreq.start = 1'b1;
            state_in = S_SCAN_WAIT;
         end
         S_SCAN_WAIT: begin
            if (srsp.done) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (release_ff) begin
               if (srsp.found) begin
                  wr_en = 1'b1;
                  wr_valid = hit_count > 16'd1;
                  wr_count = hit_count - 16'd1;
               end
               state_in = (op_ff == OP_SWEEP) ? S_Q_READ : S_DONE;
            end else begin
               if (srsp.found) begin
                  if (limit_ff != '0 && hit_count >= limit_ff) begin
                     status_in = ST_LIMIT;
                  end else begin
                     wr_en = 1'b1;
                     wr_count = new_count;
                     acc_in = 1'b1;
                     if (new_count >= PRIO_THRESHOLD) prio_in = -{1'b0, new_count};
                  end
               end else if (srsp.free_found) begin
                  wr_en = 1'b1;
                  wr_index = free_index;
                  acc_in = 1'b1;
               end else begin
                  status_in = ST_TABLE_FULL;
               end
               state_in = S_DONE;
            end
         end
         S_Q_READ: state_in = S_Q_WAIT;
         S_Q_WAIT: state_in = S_Q_CHECK;
         S_Q_CHECK: begin
            if (tick_ff >= window_ff && fill_ff != '0
                && q_time < tick_ff - window_ff) begin
               key_in = q_prefix;
               head_in = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               fill_in = fill_ff - 1'b1;
               if (tally_ff < TALLY_MAX) tally_in = tally_ff + 9'd1;
               release_in = 1'b1;
               state_in = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (op_ff == OP_CLOSE && !release_ff) begin
               push = 1'b1;
               tail_in = (tail_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
               fill_in = fill_ff + 1'b1;
            end
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         valid_ff <= valid_in;
      end
      op_ff <= op_in;
      key_ff <= key_in;
      tick_ff <= tick_in;
      tally_ff <= tally_in;
      release_ff <= release_in;
      acc_ff <= acc_in;
      prio_ff <= prio_in;
      status_ff <= status_in;
   end

   assign busy = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;
   assign rsp_accepted = acc_ff;
   assign rsp_priority_res = prio_ff;
   assign rsp_status = status_ff;
   assign rsp_expired_count = (op_ff == OP_SWEEP) ? tally_ff : 9'd0;
endmodule

/* rtl/core/pscl_table.sv */
module pscl_table #(
   parameter int TABLE_DEPTH = 64,
   parameter int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pscl_pkg::search_req_type search_req,
   output pscl_pkg::search_rsp_type search_rsp,
   output logic [TW-1:0]           hit_index,
   output logic [TW-1:0]           free_index,
   output logic [15:0]             hit_count,
   input  logic                    wr_en,
   input  logic [TW-1:0]           wr_index,
   input  logic                    wr_valid,
   input  logic [63:0]             wr_prefix,
   input  logic [15:0]             wr_count
);
   import pscl_pkg::*;

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [63:0]            prefix_mem [TABLE_DEPTH];
   logic [15:0]            count_mem  [TABLE_DEPTH];

   logic          busy_ff, busy_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          last_ff, last_in;
   logic [TW-1:0] addr_ff, addr_in;
   logic [TW-1:0] rd_addr_ff;
   logic [63:0]   rd_prefix_ff;
   logic [15:0]   rd_count_ff;
   logic          found_ff, found_in;
   logic          free_ff, free_in;
   logic [TW-1:0] hit_ff, hit_in;
   logic [TW-1:0] freei_ff, freei_in;
   logic [15:0]   hcount_ff, hcount_in;
   logic          done_ff, done_in;
   logic [63:0]   key_ff, key_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prefix_mem[wr_index] <= wr_prefix;
         count_mem[wr_index]  <= wr_count;
      end
      rd_prefix_ff <= prefix_mem[addr_ff];
      rd_count_ff  <= count_mem[addr_ff];
      rd_addr_ff   <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_index] <= wr_valid;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      rd_pend_in = 1'b0;
      last_in = last_ff;
      addr_in = addr_ff;
      found_in = found_ff;
      free_in = free_ff;
      hit_in = hit_ff;
      freei_in = freei_ff;
      hcount_in = hcount_ff;
      done_in = 1'b0;
      key_in = key_ff;
      if (search_req.start) begin
         busy_in = 1'b1;
         addr_in = '0;
         last_in = 1'b0;
         found_in = 1'b0;
         free_in = 1'b0;
         key_in = search_req.key;
      end else if (busy_ff) begin
         if (!last_ff) begin
            rd_pend_in = 1'b1;
            if (addr_ff == TW'(TABLE_DEPTH - 1)) begin
               last_in = 1'b1;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
      end
      if (rd_pend_ff) begin
         if (valid_ff[rd_addr_ff] && rd_prefix_ff == key_ff && !found_in) begin
            found_in = 1'b1;
            hit_in = rd_addr_ff;
            hcount_in = rd_count_ff;
         end
         if (!valid_ff[rd_addr_ff] && !free_in) begin
            free_in = 1'b1;
            freei_in = rd_addr_ff;
         end
         if (last_ff && !rd_pend_in) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rd_pend_ff <= rd_pend_in;
         done_ff <= done_in;
      end
      last_ff <= last_in;
      addr_ff <= addr_in;
      found_ff <= found_in;
      free_ff <= free_in;
      hit_ff <= hit_in;
      freei_ff <= freei_in;
      hcount_ff <= hcount_in;
      key_ff <= key_in;
   end

   assign search_rsp.done = done_ff;
   assign search_rsp.found = found_ff;
   assign search_rsp.free_found = free_ff;
   assign hit_index = hit_ff;
   assign free_index = freei_ff;
   assign hit_count = hcount_ff;
endmodule

/* rtl/core/pscl_queue.sv */
module pscl_queue #(
   parameter int QUEUE_DEPTH = 256,
   parameter int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic          clock,
   input  logic          push,
   input  logic [QW-1:0] push_addr,
   input  logic [63:0]   push_prefix,
   input  logic [31:0]   push_time,
   input  logic [QW-1:0] rd_addr,
   output logic [63:0]   rd_prefix,
   output logic [31:0]   rd_time
);
   logic [95:0] mem [QUEUE_DEPTH];
   logic [95:0] rd_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[push_addr] <= {push_prefix, push_time};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_prefix = rd_ff[95:32];
   assign rd_time   = rd_ff[31:0];
endmodule

/* rtl/core/pscl_checker.sv */
module pscl_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_accepted,
   input logic [16:0] rsp_priority_res,
   input logic [1:0]  rsp_status
);
   import pscl_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("transaction not taken");
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("strobe longer than one cycle");
   a_prio_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_priority_res == '0)
      else $error("priority without admission");
   a_acc_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_status == ST_OK)
      else $error("admitted with error status");
endmodule

bind per_source_connection_limiter pscl_checker u_pscl_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_accepted,
   .rsp_priority_res, .rsp_status
);
